// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers included by the top-level design file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define AST_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define AST_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/icmper_pkg.sv
// ---------------------------------------------------------------------------
// icmper_pkg
// shared types, codes and checksum helpers of the icmp echo responder
// ---------------------------------------------------------------------------
package icmper_pkg;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_PING = 2'd2,
        OP_PULL = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic        last;
        logic [31:0] peer;
    } t_cmd;

    typedef struct packed {
        logic tx_pending;
        logic rtt_known;
    } t_back_stat;

    localparam logic [7:0]  TYPE_REQUEST   = 8'd8;
    localparam logic [7:0]  TYPE_REPLY     = 8'd0;
    localparam int          HDR_BYTES      = 8;
    localparam int          TICK_W         = 31;
    localparam logic [15:0] PING_IDENT_RST = 16'hA10A;

    // ones' complement add with end-around carry
    function automatic logic [15:0] sum_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    // fixed part of the ping checksum: type word plus payload words
    function automatic logic [15:0] ping_base_sum(input int n);
        logic [15:0] s;
        logic [7:0]  b;
        s = {TYPE_REQUEST, 8'd0};
        for (int k = 0; k < n; k++) begin
            b = 8'(k);
            s = sum_add(s, (k % 2 == 1) ? {8'd0, b} : {b, 8'd0});
        end
        return s;
    endfunction

endpackage

// File: design/icmper_if.sv
// ---------------------------------------------------------------------------
// icmper channel interfaces
// command input, result output and identifier write channels
// ---------------------------------------------------------------------------
interface icmper_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        byte_last;
    logic [31:0] peer_addr;
    modport source (output valid, action, data_byte, byte_last, peer_addr, input ready);
    modport sink   (input valid, action, data_byte, byte_last, peer_addr, output ready);
endinterface

interface icmper_out_if #(parameter int LEN_W = 11);
    logic             valid;
    logic             ready;
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic             tx_last;
    logic [31:0]      tx_dest;
    logic [LEN_W-1:0] tx_length;
    logic [30:0]      rtt;
    logic             rtt_valid;
    modport source (output valid, tx_valid, tx_byte, tx_last, tx_dest, tx_length, rtt,
                    rtt_valid, input ready);
    modport sink   (input valid, tx_valid, tx_byte, tx_last, tx_dest, tx_length, rtt,
                    rtt_valid, output ready);
endinterface

interface icmper_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] ping_ident;
    modport source (output valid, ping_ident, input ready);
    modport sink   (input valid, ping_ident, output ready);
endinterface

// File: design/icmper_front.sv
// ---------------------------------------------------------------------------
// icmper_front
// accepts command transactions and classifies them into queue entries
// ---------------------------------------------------------------------------
module icmper_front (
    icmper_in_if.sink          i_cmd,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output icmper_pkg::t_cmd   o_push_cmd
);

    always_comb begin
        o_push_cmd      = '0;
        o_push_cmd.data = i_cmd.data_byte;
        o_push_cmd.last = i_cmd.byte_last;
        o_push_cmd.peer = i_cmd.peer_addr;
        unique case (i_cmd.action)
            icmper_pkg::OP_BYTE: o_push_cmd.op = icmper_pkg::OP_BYTE;
            icmper_pkg::OP_TICK: o_push_cmd.op = icmper_pkg::OP_TICK;
            icmper_pkg::OP_PING: o_push_cmd.op = icmper_pkg::OP_PING;
            default:             o_push_cmd.op = icmper_pkg::OP_PULL;
        endcase
        // only receive bytes care about the last flag
        if (o_push_cmd.op != icmper_pkg::OP_BYTE) begin
            o_push_cmd.last = 1'b0;
        end
    end

    assign o_push_valid = i_cmd.valid;
    assign i_cmd.ready  = i_push_ready;

endmodule

// File: design/icmper_queue.sv
// ---------------------------------------------------------------------------
// icmper_queue
// two-entry queue between front and back
// ---------------------------------------------------------------------------
module icmper_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  icmper_pkg::t_cmd i_push_cmd,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output icmper_pkg::t_cmd o_pop_cmd
);

    icmper_pkg::t_cmd r_ent [2];
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_cnt, n_cnt;
    logic             push, pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_cmd    = r_ent[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_ent[r_wp] <= i_push_cmd;
        end
    end

endmodule

// File: design/icmper_back.sv
// ---------------------------------------------------------------------------
// icmper_back
// executes queued commands: message store, checksum, transmit, round trip
// ---------------------------------------------------------------------------
module icmper_back #(
    parameter int MAX_MSG_BYTES   = 1500,
    parameter int PING_DATA_BYTES = 32,
    parameter int LEN_W           = 11
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_ready,
    input  icmper_pkg::t_cmd       i_cmd,
    input  logic [15:0]            i_ping_ident,
    output icmper_pkg::t_back_stat o_stat,
    icmper_out_if.source           o_res
);

    localparam int AW = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_MSG_BYTES);
    localparam logic [LEN_W-1:0] PING_LEN = LEN_W'(icmper_pkg::HDR_BYTES + PING_DATA_BYTES);
    localparam logic [LEN_W-1:0] HDR_LEN  = LEN_W'(icmper_pkg::HDR_BYTES);
    localparam logic [15:0] PING_BASE = icmper_pkg::ping_base_sum(PING_DATA_BYTES);
    localparam logic [30:0] TICK_MAX  = '1;

    logic [7:0] mem [MAX_MSG_BYTES];
    logic [7:0] r_rd;
    logic       mem_we;
    logic [AW-1:0] mem_wa;

    logic [LEN_W-1:0] r_rx_count, n_rx_count;
    logic             r_rx_ovf, n_rx_ovf;
    logic [15:0]      r_rx_sum, n_rx_sum;
    logic [7:0]       r_rx_type, n_rx_type;
    logic [15:0]      r_rx_ident, n_rx_ident;
    logic [31:0]      r_rx_peer, n_rx_peer;
    logic             r_tx_pending, n_tx_pending;
    logic             r_tx_is_ping, n_tx_is_ping;
    logic [LEN_W-1:0] r_tx_index, n_tx_index;
    logic [LEN_W-1:0] r_tx_len, n_tx_len;
    logic [15:0]      r_tx_cks, n_tx_cks;
    logic [31:0]      r_tx_target, n_tx_target;
    logic [15:0]      r_tx_ident, n_tx_ident;
    logic [15:0]      r_ping_seq, n_ping_seq;
    logic [30:0]      r_elapsed, n_elapsed;
    logic [30:0]      r_rtt, n_rtt;
    logic             r_rtt_known, n_rtt_known;

    logic             r_out_valid;
    logic             r_out_tx_valid, n_out_tx_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_last, n_out_last;
    logic [31:0]      r_out_dest, n_out_dest;
    logic [LEN_W-1:0] r_out_len, n_out_len;

    logic             take;
    logic [LEN_W-1:0] idx;
    logic [7:0]       b;
    logic [LEN_W:0]   idx_next;

    assign o_cmd_ready = !r_out_valid || o_res.ready;
    assign take        = i_cmd_valid && o_cmd_ready;
    assign idx         = r_tx_index;
    assign idx_next    = {1'b0, r_tx_index} + 1'b1;
    assign b           = i_cmd.data;

    always_comb begin
        n_rx_count   = r_rx_count;
        n_rx_ovf     = r_rx_ovf;
        n_rx_sum     = r_rx_sum;
        n_rx_type    = r_rx_type;
        n_rx_ident   = r_rx_ident;
        n_rx_peer    = r_rx_peer;
        n_tx_pending = r_tx_pending;
        n_tx_is_ping = r_tx_is_ping;
        n_tx_index   = r_tx_index;
        n_tx_len     = r_tx_len;
        n_tx_cks     = r_tx_cks;
        n_tx_target  = r_tx_target;
        n_tx_ident   = r_tx_ident;
        n_ping_seq   = r_ping_seq;
        n_elapsed    = r_elapsed;
        n_rtt        = r_rtt;
        n_rtt_known  = r_rtt_known;
        n_out_tx_valid = 1'b0;
        n_out_byte     = 8'd0;
        n_out_last     = 1'b0;
        n_out_dest     = 32'd0;
        n_out_len      = '0;
        mem_we         = 1'b0;
        mem_wa         = r_rx_count[AW-1:0];

        if (take) begin
            unique case (i_cmd.op)
                icmper_pkg::OP_BYTE: begin
                    if (r_tx_pending || (r_rx_count >= MAX_LEN)) begin
                        n_rx_ovf = 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        if (r_rx_count == '0) begin
                            n_rx_peer = i_cmd.peer;
                            n_rx_type = b;
                        end
                        if (r_rx_count == LEN_W'(4)) begin
                            n_rx_ident[15:8] = b;
                        end
                        if (r_rx_count == LEN_W'(5)) begin
                            n_rx_ident[7:0] = b;
                        end
                        // type byte and checksum field stay out of the sum
                        if (r_rx_count != '0 && r_rx_count != LEN_W'(2)
                            && r_rx_count != LEN_W'(3)) begin
                            n_rx_sum = icmper_pkg::sum_add(r_rx_sum,
                                r_rx_count[0] ? {8'd0, b} : {b, 8'd0});
                        end
                        n_rx_count = r_rx_count + 1'b1;
                    end
                    if (i_cmd.last) begin
                        if (!n_rx_ovf && n_rx_count >= HDR_LEN) begin
                            if (n_rx_type == icmper_pkg::TYPE_REQUEST) begin
                                n_tx_cks     = ~n_rx_sum;
                                n_tx_pending = 1'b1;
                                n_tx_is_ping = 1'b0;
                                n_tx_index   = '0;
                                n_tx_len     = n_rx_count;
                                n_tx_target  = n_rx_peer;
                            end else if (n_rx_type == icmper_pkg::TYPE_REPLY
                                         && n_rx_ident == i_ping_ident) begin
                                n_rtt       = r_elapsed;
                                n_rtt_known = 1'b1;
                            end
                        end
                        n_rx_count = '0;
                        n_rx_ovf   = 1'b0;
                        n_rx_sum   = 16'd0;
                        n_rx_type  = 8'd0;
                        n_rx_ident = 16'd0;
                    end
                end
                icmper_pkg::OP_TICK: begin
                    if (r_elapsed != TICK_MAX) begin
                        n_elapsed = r_elapsed + 1'b1;
                    end
                end
                icmper_pkg::OP_PING: begin
                    if (!r_tx_pending) begin
                        n_ping_seq   = r_ping_seq + 1'b1;
                        n_tx_ident   = i_ping_ident;
                        n_tx_cks     = ~icmper_pkg::sum_add(
                            icmper_pkg::sum_add(PING_BASE, i_ping_ident), n_ping_seq);
                        n_tx_pending = 1'b1;
                        n_tx_is_ping = 1'b1;
                        n_tx_index   = '0;
                        n_tx_len     = PING_LEN;
                        n_tx_target  = i_cmd.peer;
                        n_elapsed    = 31'd0;
                        n_rtt_known  = 1'b0;
                    end
                end
                icmper_pkg::OP_PULL: begin
                    if (r_tx_pending) begin
                        n_out_tx_valid = 1'b1;
                        n_out_dest     = r_tx_target;
                        n_out_len      = r_tx_len;
                        if (idx == LEN_W'(2)) begin
                            n_out_byte = r_tx_cks[15:8];
                        end else if (idx == LEN_W'(3)) begin
                            n_out_byte = r_tx_cks[7:0];
                        end else if (r_tx_is_ping) begin
                            case (idx)
                                LEN_W'(0): n_out_byte = icmper_pkg::TYPE_REQUEST;
                                LEN_W'(1): n_out_byte = 8'd0;
                                LEN_W'(4): n_out_byte = r_tx_ident[15:8];
                                LEN_W'(5): n_out_byte = r_tx_ident[7:0];
                                LEN_W'(6): n_out_byte = r_ping_seq[15:8];
                                LEN_W'(7): n_out_byte = r_ping_seq[7:0];
                                default:   n_out_byte = 8'(idx - HDR_LEN);
                            endcase
                        end else if (idx == '0) begin
                            n_out_byte = icmper_pkg::TYPE_REPLY;
                        end else begin
                            n_out_byte = r_rd;
                        end
                        if (idx_next >= {1'b0, r_tx_len}) begin
                            n_out_last   = 1'b1;
                            n_tx_pending = 1'b0;
                            n_tx_index   = '0;
                        end else begin
                            n_tx_index = idx_next[LEN_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // buffer is frozen while a transaction is pending, so reading ahead is safe
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= b;
        end
        r_rd <= mem[n_tx_index[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_count   <= '0;
            r_rx_ovf     <= 1'b0;
            r_rx_sum     <= 16'd0;
            r_rx_type    <= 8'd0;
            r_rx_ident   <= 16'd0;
            r_rx_peer    <= 32'd0;
            r_tx_pending <= 1'b0;
            r_tx_is_ping <= 1'b0;
            r_tx_index   <= '0;
            r_tx_len     <= '0;
            r_tx_cks     <= 16'd0;
            r_tx_target  <= 32'd0;
            r_tx_ident   <= 16'd0;
            r_ping_seq   <= 16'd0;
            r_elapsed    <= 31'd0;
            r_rtt        <= 31'd0;
            r_rtt_known  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rx_count   <= n_rx_count;
            r_rx_ovf     <= n_rx_ovf;
            r_rx_sum     <= n_rx_sum;
            r_rx_type    <= n_rx_type;
            r_rx_ident   <= n_rx_ident;
            r_rx_peer    <= n_rx_peer;
            r_tx_pending <= n_tx_pending;
            r_tx_is_ping <= n_tx_is_ping;
            r_tx_index   <= n_tx_index;
            r_tx_len     <= n_tx_len;
            r_tx_cks     <= n_tx_cks;
            r_tx_target  <= n_tx_target;
            r_tx_ident   <= n_tx_ident;
            r_ping_seq   <= n_ping_seq;
            r_elapsed    <= n_elapsed;
            r_rtt        <= n_rtt;
            r_rtt_known  <= n_rtt_known;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (take) begin
            r_out_tx_valid <= n_out_tx_valid;
            r_out_byte     <= n_out_byte;
            r_out_last     <= n_out_last;
            r_out_dest     <= n_out_dest;
            r_out_len      <= n_out_len;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.tx_valid  = r_out_tx_valid;
    assign o_res.tx_byte   = r_out_byte;
    assign o_res.tx_last   = r_out_last;
    assign o_res.tx_dest   = r_out_dest;
    assign o_res.tx_length = r_out_len;
    // rtt fields track live state; a result register load follows every change
    assign o_res.rtt       = r_rtt_known ? r_rtt : 31'd0;
    assign o_res.rtt_valid = r_rtt_known;

    assign o_stat.tx_pending = r_tx_pending;
    assign o_stat.rtt_known  = r_rtt_known;

endmodule

// File: design/icmper_top_stub.sv
// ---------------------------------------------------------------------------
// icmper_ident_reg
// holds the ping identifier written through the configuration channel
// ---------------------------------------------------------------------------
module icmper_ident_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    icmper_cfg_if.sink  i_cfg,
    output logic [15:0] o_ping_ident
);

    logic [15:0] r_ping_ident;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ping_ident <= icmper_pkg::PING_IDENT_RST;
        end else if (i_cfg.valid) begin
            r_ping_ident <= i_cfg.ping_ident;
        end
    end

    assign o_ping_ident = r_ping_ident;

endmodule

// File: design/icmp_echo_responder_pinger.sv
// ---------------------------------------------------------------------------
// icmp_echo_responder_pinger
// echo reply offload with ping generator and round-trip timer
// ---------------------------------------------------------------------------
// Every command transaction (message byte, tick, ping, pull) yields one result
// transaction. The back end executes one command per cycle while the result
// register is free or being taken, so the sustained rate is one transaction
// per cycle; a command passes through the two-entry command queue and then
// the result register. Stored message bytes live in a buffer of MAX_MSG_BYTES
// entries with one write and one read port, read one address ahead of the
// transmit index. The rtt and rtt_valid fields show the state after the
// command of that transaction. No clearing pass after reset.
`include "assert_macros.svh"

module icmp_echo_responder_pinger #(
    parameter int MAX_MSG_BYTES   = 1500,
    parameter int PING_DATA_BYTES = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    icmper_in_if.sink     i_cmd,
    icmper_cfg_if.sink    i_cfg,
    icmper_out_if.source  o_res
);

    localparam int RX_W  = $clog2(MAX_MSG_BYTES + 1);
    localparam int PG_W  = $clog2(icmper_pkg::HDR_BYTES + PING_DATA_BYTES + 1);
    localparam int LEN_W = (RX_W > PG_W) ? RX_W : PG_W;

    logic                   push_valid, push_ready, pop_valid, pop_ready;
    icmper_pkg::t_cmd       push_cmd, pop_cmd;
    icmper_pkg::t_back_stat stat;
    logic [15:0]            ping_ident;
    logic                   tx_no_len;
    logic                   tx_end_seen;

    icmper_ident_reg u_ident (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .o_ping_ident (ping_ident)
    );

    icmper_front u_front (
        .i_cmd        (i_cmd),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd)
    );

    icmper_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    icmper_back #(
        .MAX_MSG_BYTES   (MAX_MSG_BYTES),
        .PING_DATA_BYTES (PING_DATA_BYTES),
        .LEN_W           (LEN_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (pop_valid),
        .o_cmd_ready  (pop_ready),
        .i_cmd        (pop_cmd),
        .i_ping_ident (ping_ident),
        .o_stat       (stat),
        .o_res        (o_res)
    );

    assign tx_no_len   = o_res.valid && o_res.tx_valid && (o_res.tx_length == '0);
    assign tx_end_seen = o_res.valid && o_res.tx_last;

    `AST_NEVER(a_len_nonzero, i_clk, i_rst_n, tx_no_len, "transmit byte with zero length")
    `AST_NEVER(a_rtt_zero, i_clk, i_rst_n, !stat.rtt_known && o_res.rtt != 31'd0, "stale rtt")
    `AST_HOLDS(a_tx_end, i_clk, i_rst_n, $fell(stat.tx_pending) |-> tx_end_seen, "no last byte")

endmodule

// File: tb/sv/icmp_echo_responder_pinger_test.sv
// ---------------------------------------------------------------------------
// icmp_echo_responder_pinger_test
// drives command transactions, predicts every result and compares them
// ---------------------------------------------------------------------------
module icmp_echo_responder_pinger_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES  = 1500;
    localparam int PING_BYTES = 32;
    localparam logic [30:0] TICK_SAT = 31'h7FFFFFFF;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [31:0] tx_dest;
        logic [10:0] tx_length;
        logic [30:0] rtt;
        logic        rtt_valid;
    } t_echo_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    icmper_in_if  cmd_ch ();
    icmper_cfg_if cfg_ch ();
    icmper_out_if res_ch ();

    icmp_echo_responder_pinger dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] m_ident;
    logic [7:0]  m_buf [MAX_BYTES];
    int          m_rx_count;
    logic        m_rx_drop;
    logic [15:0] m_rx_sum;
    logic [7:0]  m_rx_type;
    logic [15:0] m_rx_ident;
    logic [31:0] m_rx_peer;
    logic        m_tx_busy;
    logic        m_tx_ping;
    int          m_tx_idx;
    int          m_tx_len;
    logic [15:0] m_tx_csum;
    logic [31:0] m_tx_dest;
    logic [15:0] m_tx_ident;
    logic [15:0] m_seq;
    logic [30:0] m_ticks;
    logic [30:0] m_rtt;
    logic        m_rtt_known;

    icmper_pkg::t_cmd pending_cmds [$];
    t_echo_res expected_res [$];
    logic      cfg_pending = 1'b0;
    logic [15:0] cfg_value = '0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    logic      hold_off = 1'b0;
    bit        failed = 1'b0;

    function automatic logic [15:0] ones_add(logic [15:0] s, logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    function automatic void model_reset();
        m_ident = icmper_pkg::PING_IDENT_RST;
        m_rx_count = 0; m_rx_drop = 0; m_rx_sum = 0; m_rx_type = 0; m_rx_ident = 0;
        m_rx_peer = 0; m_tx_busy = 0; m_tx_ping = 0; m_tx_idx = 0; m_tx_len = 0;
        m_tx_csum = 0; m_tx_dest = 0; m_tx_ident = 0; m_seq = 0; m_ticks = 0;
        m_rtt = 0; m_rtt_known = 0;
    endfunction

    function automatic void finish_message();
        if (!m_rx_drop && m_rx_count >= icmper_pkg::HDR_BYTES) begin
            if (m_rx_type == icmper_pkg::TYPE_REQUEST) begin
                m_tx_csum = ~m_rx_sum;
                m_tx_busy = 1; m_tx_ping = 0; m_tx_idx = 0;
                m_tx_len = m_rx_count; m_tx_dest = m_rx_peer;
            end else if (m_rx_type == icmper_pkg::TYPE_REPLY && m_rx_ident == m_ident) begin
                m_rtt = m_ticks; m_rtt_known = 1;
            end
        end
        m_rx_count = 0; m_rx_drop = 0; m_rx_sum = 0; m_rx_type = 0; m_rx_ident = 0;
    endfunction

    function automatic logic [7:0] tx_byte_of(int i);
        if (i == 2) return m_tx_csum[15:8];
        if (i == 3) return m_tx_csum[7:0];
        if (m_tx_ping) begin
            case (i)
                0: return icmper_pkg::TYPE_REQUEST;
                1: return 8'd0;
                4: return m_tx_ident[15:8];
                5: return m_tx_ident[7:0];
                6: return m_seq[15:8];
                7: return m_seq[7:0];
                default: return 8'(i - icmper_pkg::HDR_BYTES);
            endcase
        end
        if (i == 0) return icmper_pkg::TYPE_REPLY;
        return m_buf[i];
    endfunction

    function automatic t_echo_res predict_echo(icmper_pkg::t_cmd c);
        t_echo_res r;
        logic [15:0] s;
        int i;
        r = '0;
        case (c.op)
            icmper_pkg::OP_BYTE: begin
                if (m_tx_busy || m_rx_count >= MAX_BYTES) begin
                    m_rx_drop = 1;
                end else begin
                    i = m_rx_count;
                    if (i == 0) begin
                        m_rx_peer = c.peer;
                        m_rx_type = c.data;
                    end
                    m_buf[i] = c.data;
                    if (i == 4) m_rx_ident[15:8] = c.data;
                    if (i == 5) m_rx_ident[7:0] = c.data;
                    if (i != 0 && i != 2 && i != 3)
                        m_rx_sum = ones_add(m_rx_sum, i[0] ? {8'd0, c.data} : {c.data, 8'd0});
                    m_rx_count = i + 1;
                end
                if (c.last) finish_message();
            end
            icmper_pkg::OP_TICK: if (m_ticks != TICK_SAT) m_ticks++;
            icmper_pkg::OP_PING: if (!m_tx_busy) begin
                m_seq++;
                m_tx_ident = m_ident;
                s = {icmper_pkg::TYPE_REQUEST, 8'd0};
                s = ones_add(s, m_tx_ident);
                s = ones_add(s, m_seq);
                for (int k = 0; k < PING_BYTES; k++)
                    s = ones_add(s, k[0] ? {8'd0, 8'(k)} : {8'(k), 8'd0});
                m_tx_csum = ~s;
                m_tx_busy = 1; m_tx_ping = 1; m_tx_idx = 0;
                m_tx_len = icmper_pkg::HDR_BYTES + PING_BYTES; m_tx_dest = c.peer;
                m_ticks = 0; m_rtt_known = 0;
            end
            default: if (m_tx_busy) begin
                r.tx_valid = 1;
                r.tx_byte = tx_byte_of(m_tx_idx);
                r.tx_dest = m_tx_dest;
                r.tx_length = 11'(m_tx_len);
                if (m_tx_idx + 1 >= m_tx_len) begin
                    r.tx_last = 1; m_tx_busy = 0; m_tx_idx = 0;
                end else begin
                    m_tx_idx++;
                end
            end
        endcase
        r.rtt = m_rtt_known ? m_rtt : '0;
        r.rtt_valid = m_rtt_known;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready)
                expected_res.push_back(predict_echo(icmper_pkg::t_cmd'({cmd_ch.action,
                    cmd_ch.data_byte, cmd_ch.byte_last, cmd_ch.peer_addr})));
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    icmper_pkg::t_cmd c;
                    c = pending_cmds.pop_front();
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.action <= c.op;
                    cmd_ch.data_byte <= c.data;
                    cmd_ch.byte_last <= c.last;
                    cmd_ch.peer_addr <= c.peer;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // configuration writer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            m_ident = cfg_ch.ping_ident;
            cfg_ch.valid <= 1'b0;
            cfg_pending <= 1'b0;
        end else if (cfg_pending && !cfg_ch.valid) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.ping_ident <= cfg_value;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                t_echo_res got, want;
                got = {res_ch.tx_valid, res_ch.tx_byte, res_ch.tx_last, res_ch.tx_dest,
                       res_ch.tx_length, res_ch.rtt, res_ch.rtt_valid};
                if (expected_res.size() == 0) begin
                    $display("%0t: unexpected result transaction %h", $time, got);
                    failed = 1'b1;
                end else begin
                    want = expected_res.pop_front();
                    if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                        got.tx_last !== want.tx_last || got.tx_dest !== want.tx_dest ||
                        got.tx_length !== want.tx_length || got.rtt !== want.rtt ||
                        got.rtt_valid !== want.rtt_valid) begin
                        $display("%0t: result mismatch expected %h actual %h",
                                 $time, want, got);
                        failed = 1'b1;
                    end
                end
            end
            res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic icmper_pkg::t_cmd mk(icmper_pkg::t_op op, logic [7:0] d, logic l,
                                            logic [31:0] p);
        icmper_pkg::t_cmd c;
        c.op = op; c.data = d; c.last = l; c.peer = p;
        return c;
    endfunction

    // one received message of the given length, with random peer and filler bytes
    task automatic queue_message(logic [7:0] kind, logic [15:0] ident, int len);
        logic [31:0] peer;
        logic [7:0] b;
        peer = $urandom;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (i == 0) b = kind;
            if (i == 4) b = ident[15:8];
            if (i == 5) b = ident[7:0];
            pending_cmds.push_back(mk(icmper_pkg::OP_BYTE, b, i == len - 1, peer));
        end
    endtask

    task automatic queue_pulls(int n);
        repeat (n) pending_cmds.push_back(mk(icmper_pkg::OP_PULL, 8'($urandom),
                                             1'($urandom), $urandom));
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || cmd_ch.valid || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_ident(logic [15:0] v);
        cfg_value = v;
        cfg_pending = 1'b1;
        while (cfg_pending) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic random_traffic(int n);
        int pick, len;
        while (n > 0) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(8, 40);
                queue_message(($urandom_range(3) == 0) ? 8'($urandom)
                                                       : icmper_pkg::TYPE_REQUEST,
                              16'($urandom), len);
                queue_pulls(len + 2);
                n -= 2 * len;
            end else if (pick < 55) begin
                queue_message(icmper_pkg::TYPE_REPLY,
                              ($urandom_range(3) == 0) ? 16'($urandom) : m_ident,
                              $urandom_range(8, 16));
                n -= 12;
            end else if (pick < 70) begin
                pending_cmds.push_back(mk(icmper_pkg::OP_PING, 8'($urandom), 1'($urandom),
                                          $urandom));
                queue_pulls($urandom_range(10, 42));
                n -= 30;
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 8))
                    pending_cmds.push_back(mk(icmper_pkg::OP_TICK, 8'($urandom),
                                              1'($urandom), $urandom));
                n -= 4;
            end else begin
                pending_cmds.push_back(mk(icmper_pkg::t_op'($urandom_range(3)), 8'($urandom),
                                          1'($urandom), $urandom));
                n -= 1;
            end
        end
    endtask

    initial begin
        cmd_ch.valid = 1'b0; cmd_ch.action = icmper_pkg::OP_TICK; cmd_ch.data_byte = '0;
        cmd_ch.byte_last = 1'b0; cmd_ch.peer_addr = '0;
        cfg_ch.valid = 1'b0; cfg_ch.ping_ident = '0;
        res_ch.ready = 1'b0;
        model_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: pull while idle, a too-short and a header-only request, a ping and a tick
        queue_pulls(1);
        queue_message(icmper_pkg::TYPE_REQUEST, 16'h0000, 7);
        queue_message(icmper_pkg::TYPE_REQUEST, 16'hFFFF, 8);
        // dropped while busy
        pending_cmds.push_back(mk(icmper_pkg::OP_BYTE, 8'hFF, 1'b0, '1));
        // ignored while busy
        pending_cmds.push_back(mk(icmper_pkg::OP_PING, 8'h00, 1'b0, '1));
        queue_pulls(8);
        pending_cmds.push_back(mk(icmper_pkg::OP_PING, 8'hFF, 1'b1, 32'h0));
        pending_cmds.push_back(mk(icmper_pkg::OP_TICK, 8'h00, 1'b0, 32'h0));
        queue_pulls(40);
        drain();

        write_ident(16'h0000);
        send_idle_pct = 52;
        random_traffic(300);
        drain();

        write_ident(16'hFFFF);
        send_idle_pct = 0; recv_stall_pct = 52;
        random_traffic(300);
        // pressure: receiver holds off while commands keep coming
        hold_off = 1'b1;
        repeat (60) @(posedge i_clk);
        hold_off = 1'b0;
        drain();

        write_ident(16'($urandom));
        send_idle_pct = 19; recv_stall_pct = 19;
        random_traffic(300);
        drain();

        write_ident(icmper_pkg::PING_IDENT_RST);
        send_idle_pct = 0; recv_stall_pct = 0;
        random_traffic(300);
        drain();

        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #40ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
